// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define BCPA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BCPA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/bcpa_pkg.sv
// ----------------------------------------------------------------------------
// bcpa_pkg
// Types and constants of the contiguous page allocator.
// ----------------------------------------------------------------------------
package bcpa_pkg;

    localparam int BYTE_BITS = 8;
    localparam int BIT_MSB   = 7;
    localparam int CNT_W     = 13;
    localparam int ADDR_W    = 48;
    localparam int RUN_W     = CNT_W + 1;

    localparam logic REG_POOL_BASE     = 1'b0;
    localparam logic REG_MANAGED_PAGES = 1'b1;

    localparam logic [CNT_W-1:0] MANAGED_RESET = CNT_W'(4096);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_MARK,
        ST_MUL,
        ST_ADD
    } state_t;

    typedef struct packed {
        logic             hit;
        logic [2:0]       hit_pos;
        logic [CNT_W-1:0] run_out;
    } scan_res_t;

endpackage

// File: rtl/bcpa_cell.sv
// ----------------------------------------------------------------------------
// bcpa_cell
// One byte of the used-page map; passes its byte to the next cell on shift.
// ----------------------------------------------------------------------------
module bcpa_cell
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       shift,
    input  logic [7:0] d,
    output logic [7:0] q
);

    logic [7:0] byte_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_reg <= '0;
        end
        else if (shift)
        begin
            byte_reg <= d;
        end
    end

    assign q = byte_reg;

endmodule

// File: rtl/bcpa_scan.sv
// ----------------------------------------------------------------------------
// bcpa_scan
// Head of the map ring: free-run tracking over one byte and run marking.
// ----------------------------------------------------------------------------
module bcpa_scan
#(
    parameter int BW = 9,
    parameter int PW = 12
)
(
    input  logic [7:0]                byte_in,
    input  logic [BW-1:0]             byte_idx,
    input  logic [bcpa_pkg::CNT_W-1:0] run_in,
    input  logic [bcpa_pkg::CNT_W-1:0] req,
    input  logic [bcpa_pkg::CNT_W-1:0] limit,
    input  logic                      mark_en,
    input  logic [PW-1:0]             mark_lo,
    input  logic [PW-1:0]             mark_hi,
    output bcpa_pkg::scan_res_t       res,
    output logic [7:0]                byte_out
);

    import bcpa_pkg::*;

    localparam int XW = (PW > CNT_W) ? PW : CNT_W;

    always_comb
    begin
        logic [RUN_W-1:0] run;
        logic [PW-1:0]    page;
        logic             free;
        run      = RUN_W'(run_in);
        res      = '0;
        byte_out = byte_in;
        page     = '0;
        free     = 1'b0;
        for (int j = 0; j < BYTE_BITS; j++)
        begin
            page = {byte_idx, 3'(j)};
            free = !byte_in[BIT_MSB - j] && (XW'(page) < XW'(limit));
            if (free)
            begin
                run = run + 1'b1;
            end
            else
            begin
                run = '0;
            end
            if (!res.hit && run == RUN_W'(req))
            begin
                res.hit     = 1'b1;
                res.hit_pos = 3'(j);
            end
            if (mark_en && page >= mark_lo && page <= mark_hi)
            begin
                byte_out[BIT_MSB - j] = 1'b1;
            end
        end
        res.run_out = run[CNT_W-1:0];
    end

endmodule

// File: rtl/bitmap_contiguous_page_allocator_unit.sv
// ----------------------------------------------------------------------------
// bitmap_contiguous_page_allocator_unit
// First-fit contiguous page allocator over a used-page bitmap held in a ring
// of byte cells that rotates past a scan/mark head.
// ----------------------------------------------------------------------------
//  channel   signals                         direction
//  request   start, busy, req_pages          in (busy out)
//  result    done, granted, run_address,     out
//            pages_in_use
//  config    cfg_we, cfg_index, cfg_data     in
//
// C = ceil(NUM_PAGES / 8) byte cells. Zero request: multiply and add steps.
// Refused request: scan rotation, multiply, add. Granted request: scan
// rotation, mark rotation, multiply, add (address). Reset clears the map and
// the count and resets the control and config registers; the datapath
// registers are not reset. done is a one-cycle strobe; new requests are
// taken in the cycle done is shown.
// ----------------------------------------------------------------------------
module bitmap_contiguous_page_allocator_unit
#(
    parameter int NUM_PAGES  = 4096,
    parameter int PAGE_BYTES = 4096
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [bcpa_pkg::CNT_W-1:0]  req_pages,
    output logic                        done,
    output logic                        granted,
    output logic [bcpa_pkg::ADDR_W-1:0] run_address,
    output logic [bcpa_pkg::CNT_W-1:0]  pages_in_use,
    input  logic                        cfg_we,
    input  logic                        cfg_index,
    input  logic [bcpa_pkg::ADDR_W-1:0] cfg_data
);

    import bcpa_pkg::*;

    localparam int CELLS   = (NUM_PAGES + BYTE_BITS - 1) / BYTE_BITS;
    localparam int BW      = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int PW      = BW + 3;
    localparam int XW      = (PW > CNT_W) ? PW : CNT_W;
    localparam int PB_W    = $clog2(PAGE_BYTES + 1);
    localparam int PRW     = PW + PB_W;
    localparam int CNT_MAX = (1 << CNT_W) - 1;
    localparam int LIM_CAP = (NUM_PAGES < CNT_MAX) ? NUM_PAGES : CNT_MAX;

    state_t state_reg, state_next;

    logic [ADDR_W-1:0] pool_base_reg;
    logic [CNT_W-1:0]  managed_reg;
    logic [CNT_W-1:0]  req_reg;
    logic [CNT_W-1:0]  limit_reg;
    logic [CNT_W-1:0]  run_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [BW-1:0]     idx_reg;
    logic              found_reg;
    logic [PW-1:0]     start_reg;
    logic [PW-1:0]     end_reg;
    logic [PRW-1:0]    prod_reg;
    logic              done_reg;
    logic              granted_reg;
    logic [ADDR_W-1:0] run_address_reg;

    logic              accept;
    logic              shift;
    logic              last_byte;
    logic [CNT_W-1:0]  limit_now;
    logic [7:0]        cell_q [CELLS];
    logic [7:0]        head_new;
    logic [PW-1:0]     hit_page;
    scan_res_t         scan_res;

    assign accept    = start && !busy;
    assign shift     = (state_reg == ST_SCAN) || (state_reg == ST_MARK);
    assign last_byte = (idx_reg == BW'(CELLS - 1));
    assign limit_now = (managed_reg > CNT_W'(LIM_CAP)) ? CNT_W'(LIM_CAP) : managed_reg;
    assign hit_page  = {idx_reg, scan_res.hit_pos};

    genvar gi;
    generate
        for (gi = 0; gi < CELLS; gi++)
        begin : g_cell
            if (gi == CELLS - 1)
            begin : g_tail
                bcpa_cell u_cell
                (
                    .clk   (clk),
                    .rst_n (rst_n),
                    .shift (shift),
                    .d     (head_new),
                    .q     (cell_q[gi])
                );
            end
            else
            begin : g_body
                bcpa_cell u_cell
                (
                    .clk   (clk),
                    .rst_n (rst_n),
                    .shift (shift),
                    .d     (cell_q[gi + 1]),
                    .q     (cell_q[gi])
                );
            end
        end
    endgenerate

    bcpa_scan
    #(
        .BW (BW),
        .PW (PW)
    )
    u_scan
    (
        .byte_in  (cell_q[0]),
        .byte_idx (idx_reg),
        .run_in   (run_reg),
        .req      (req_reg),
        .limit    (limit_reg),
        .mark_en  (state_reg == ST_MARK),
        .mark_lo  (start_reg),
        .mark_hi  (end_reg),
        .res      (scan_res),
        .byte_out (head_new)
    );

    // FSM
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        busy       = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    state_next = (req_pages == '0) ? ST_MUL : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (last_byte)
                begin
                    state_next = (found_reg || scan_res.hit) ? ST_MARK : ST_MUL;
                end
            end
            ST_MARK:
            begin
                if (last_byte)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                state_next = ST_ADD;
            end
            ST_ADD:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_base_reg <= '0;
            managed_reg   <= MANAGED_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_POOL_BASE:     pool_base_reg <= cfg_data;
                REG_MANAGED_PAGES: managed_reg   <= cfg_data[CNT_W-1:0];
                default:           pool_base_reg <= pool_base_reg;
            endcase
        end
    end

    // control and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
            idx_reg   <= '0;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (accept)
            begin
                found_reg <= (req_pages == '0);
                idx_reg   <= '0;
            end
            if (shift)
            begin
                idx_reg <= last_byte ? '0 : idx_reg + 1'b1;
            end
            if (state_reg == ST_SCAN && scan_res.hit)
            begin
                found_reg <= 1'b1;
            end
            if (state_reg == ST_MUL && found_reg)
            begin
                count_reg <= count_reg + req_reg;
            end
            if (state_reg == ST_ADD)
            begin
                done_reg <= 1'b1;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg   <= req_pages;
            limit_reg <= limit_now;
            run_reg   <= '0;
            start_reg <= '0;
        end
        if (state_reg == ST_SCAN)
        begin
            run_reg <= scan_res.run_out;
            if (scan_res.hit && !found_reg)
            begin
                end_reg   <= hit_page;
                start_reg <= PW'(XW'(hit_page) - XW'(req_reg) + XW'(1));
            end
        end
        if (state_reg == ST_MUL)
        begin
            prod_reg <= PRW'(start_reg) * PRW'(PAGE_BYTES);
        end
        if (state_reg == ST_ADD)
        begin
            granted_reg     <= found_reg;
            run_address_reg <= found_reg ? pool_base_reg + ADDR_W'(prod_reg) : '0;
        end
    end

    assign done         = done_reg;
    assign granted      = granted_reg;
    assign run_address  = run_address_reg;
    assign pages_in_use = count_reg;

endmodule

// File: rtl/bcpa_checker.sv
// ----------------------------------------------------------------------------
// bcpa_checker
// Port-level checks of the page allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bcpa_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic        granted,
    input logic [47:0] run_address
);

    `BCPA_ASSERT_NXT(a_accept_busy, start && !busy, busy, "no busy after accept")
    `BCPA_ASSERT_IMP(a_done_idle, done, !busy, "done while busy")
    `BCPA_ASSERT_NXT(a_done_pulse, done, !done, "done longer than one cycle")
    `BCPA_ASSERT_IMP(a_refused_zero, done && !granted, run_address == '0,
        "refused item with nonzero address")

endmodule

bind bitmap_contiguous_page_allocator_unit bcpa_checker u_bcpa_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .granted     (granted),
    .run_address (run_address)
);
